[rtl/path_mtu_cache_unit_assert.svh]
// ---------------------------------------------------------------------------
// path mtu cache assertion macros
// shared assertion forms for the path mtu cache checkers
// ---------------------------------------------------------------------------
`ifndef PATH_MTU_CACHE_UNIT_ASSERT_SVH
`define PATH_MTU_CACHE_UNIT_ASSERT_SVH

// assertion that is off while reset is held
`define PMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// assertion that also holds across reset
`define PMC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/pmc_pkg.sv]
// ---------------------------------------------------------------------------
// pmc_pkg
// types and codes shared by the path mtu cache cells and top level
// ---------------------------------------------------------------------------
package pmc_pkg;

    localparam int SLOT_IW = 8;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_REFRESHED = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_HIT       = 3'd3,
        ST_DEFAULT   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_LIFETIME = 2'd0,
        CFG_V4_FLOOR = 2'd1,
        CFG_V6_FLOOR = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_RETIRE,
        OP_REFRESH,
        OP_LOWER,
        OP_INSERT
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_DONE
    } t_state;

    // command broadcast to every cell
    typedef struct packed {
        t_cell_op           op;
        logic               is_v6;
        logic [63:0]        addr_high;
        logic [63:0]        addr_low;
        logic [15:0]        mtu;
        logic [31:0]        exp_new;
        logic [31:0]        cmp_time;
        logic [SLOT_IW-1:0] pick;
    } t_cell_cmd;

    // what each cell reports back
    typedef struct packed {
        logic        match;
        logic        expired;
        logic [15:0] mtu;
    } t_cell_stat;

    // victim search token handed cell to cell
    typedef struct packed {
        logic               vld;
        logic               done;
        logic [SLOT_IW-1:0] idx;
        logic [31:0]        expiry;
    } t_scan;

    // time t has reached expiry e, wrapping compare
    function automatic logic reached(input logic [31:0] t, input logic [31:0] e);
        logic [31:0] d;
        d = t - e;
        return ~d[31];
    endfunction

endpackage

[rtl/pmc_cell.sv]
// ---------------------------------------------------------------------------
// pmc_cell
// one cache slot: local match, expiry check, update and victim search hop
// ---------------------------------------------------------------------------
module pmc_cell
    import pmc_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_cmd  i_cmd,
    input  t_scan      i_tok,
    output t_scan      o_tok,
    output t_cell_stat o_stat
);

    localparam logic [SLOT_IW-1:0] MY_IDX = SLOT_IW'(IDX);

    logic        r_valid;
    logic        r_is_v6;
    logic [63:0] r_hi;
    logic [63:0] r_lo;
    logic [15:0] r_mtu;
    logic [31:0] r_exp;
    t_scan       r_tok;
    t_scan       n_tok;
    logic        w_match;
    logic        w_reached;

    // local key compare and expiry check
    assign w_match   = r_valid && (r_is_v6 == i_cmd.is_v6) &&
                       (r_hi == i_cmd.addr_high) && (r_lo == i_cmd.addr_low);
    assign w_reached = r_valid && reached(i_cmd.cmp_time, r_exp);

    assign o_stat.match   = w_match;
    assign o_stat.expired = w_reached;
    assign o_stat.mtu     = r_mtu;

    // slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_TICK: begin
                    if (w_reached) r_valid <= 1'b0;
                end
                OP_RETIRE: begin
                    if (w_match) r_valid <= 1'b0;
                end
                OP_REFRESH: begin
                    if (w_match) r_exp <= i_cmd.exp_new;
                end
                OP_LOWER: begin
                    if (w_match) begin
                        r_mtu <= i_cmd.mtu;
                        r_exp <= i_cmd.exp_new;
                    end
                end
                OP_INSERT: begin
                    if (i_cmd.pick == MY_IDX) begin
                        r_valid <= 1'b1;
                        r_is_v6 <= i_cmd.is_v6;
                        r_hi    <= i_cmd.addr_high;
                        r_lo    <= i_cmd.addr_low;
                        r_mtu   <= i_cmd.mtu;
                        r_exp   <= i_cmd.exp_new;
                    end
                end
                default: ;
            endcase
        end
    end

    // victim search: first free slot, else oldest expiry
    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && !i_tok.done) begin
            if (!r_valid) begin
                n_tok.done   = 1'b1;
                n_tok.idx    = MY_IDX;
            end else if ((IDX == 0) || ((r_exp - i_tok.expiry) >> 31) != 32'd0) begin
                n_tok.idx    = MY_IDX;
                n_tok.expiry = r_exp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.done   <= n_tok.done;
        r_tok.idx    <= n_tok.idx;
        r_tok.expiry <= n_tok.expiry;
    end

    assign o_tok = r_tok;

endmodule

[rtl/path_mtu_cache_unit.sv]
// ---------------------------------------------------------------------------
// path_mtu_cache_unit
// path mtu cache over a chain of slot cells, keyed by ipv4 or ipv6 address
// ---------------------------------------------------------------------------
// channel   dir  handshake            payload
// s_axis    in   tvalid/tready        tuser: cmd, is_v6; tdata: addresses, mtu, ceiling, time
// m_axis    out  tvalid/tready        tuser: status; tdata: path_mtu and three counters
// cfg       in   i_cfg_we             i_cfg_idx, i_cfg_data
//
// every item passes from accept through S_EVAL and S_DONE into the output register.
// an update that misses also passes through S_SCAN while the victim token walks the cells.
// one item is in work at a time; the next is taken once the result is registered.
// a stalled result holds in the output register; the next item waits at its end.
// synchronous reset empties every slot and clears time and counters.
// ---------------------------------------------------------------------------
module path_mtu_cache_unit
    import pmc_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // addr_high, addr_low, mtu_in, ceiling, tick_time
    input  logic [191:0] s_axis_tdata,
    // cmd, is_v6
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // path_mtu, updates_total, hits_total, expired_total
    output logic [111:0] m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);

    localparam int CW = $clog2(NUM_SLOTS + 1);

    t_state      r_state, n_state;
    logic [31:0] r_lifetime;
    logic [15:0] r_v4_floor, r_v6_floor;
    logic [31:0] r_cur_time, n_cur_time;
    logic [31:0] r_cnt_upd, n_cnt_upd;
    logic [31:0] r_cnt_hit, n_cnt_hit;
    logic [31:0] r_cnt_exp, n_cnt_exp;
    t_cmd        r_cmd;
    logic        r_is_v6;
    logic [63:0] r_hi, r_lo;
    logic [15:0] r_mtu_in, r_ceil, r_clamp;
    logic [31:0] r_tick;
    logic [2:0]  r_res_status, n_res_status;
    logic [15:0] r_res_mtu, n_res_mtu;
    logic         r_out_valid;
    logic [111:0] r_out_data;
    logic [2:0]   r_out_user;

    t_cell_cmd   w_cmd;
    t_cell_stat  w_stat [NUM_SLOTS];
    t_scan       w_tok  [NUM_SLOTS+1];
    logic        w_scan_go;
    logic        w_any_match, w_m_expired;
    logic [15:0] w_m_mtu;
    logic [CW-1:0] w_retire_cnt;
    logic        w_addr_zero, w_bad;
    logic [15:0] w_floor, w_c0, w_c1, w_c2, w_clamp;
    logic        w_accept;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= 32'd600;
            r_v4_floor <= 16'd68;
            r_v6_floor <= 16'd1280;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIFETIME: r_lifetime <= i_cfg_data;
                CFG_V4_FLOOR: r_v4_floor <= i_cfg_data[15:0];
                CFG_V6_FLOOR: r_v6_floor <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // capture the item, ipv4 keys masked to 32 bits
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= t_cmd'(s_axis_tuser[1:0]);
            r_is_v6  <= s_axis_tuser[2];
            r_hi     <= s_axis_tuser[2] ? s_axis_tdata[63:0] : 64'd0;
            r_lo     <= s_axis_tuser[2] ? s_axis_tdata[127:64]
                                        : {32'd0, s_axis_tdata[95:64]};
            r_mtu_in <= s_axis_tdata[143:128];
            r_ceil   <= s_axis_tdata[159:144];
            r_tick   <= s_axis_tdata[191:160];
        end
    end

    // mtu clamp between family floor and ceiling
    assign w_floor = r_is_v6 ? r_v6_floor : r_v4_floor;
    assign w_c0    = (r_mtu_in == 16'd0) ? w_floor : r_mtu_in;
    assign w_c1    = (w_c0 > r_ceil) ? r_ceil : w_c0;
    assign w_c2    = (w_c1 < w_floor) ? w_floor : w_c1;
    assign w_clamp = (w_c2 > r_ceil) ? r_ceil : w_c2;

    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL) r_clamp <= w_clamp;
    end

    assign w_addr_zero = (r_hi == 64'd0) && (r_lo == 64'd0);
    assign w_bad       = w_addr_zero || (r_ceil == 16'd0) ||
                         (r_is_v6 && (r_hi[63:56] == 8'hFF));

    // combine cell reports, at most one live slot matches
    always_comb begin
        w_any_match  = 1'b0;
        w_m_expired  = 1'b0;
        w_m_mtu      = 16'd0;
        w_retire_cnt = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            w_any_match  = w_any_match | w_stat[k].match;
            w_m_expired  = w_m_expired | (w_stat[k].match & w_stat[k].expired);
            w_m_mtu      = w_m_mtu | (w_stat[k].match ? w_stat[k].mtu : 16'd0);
            w_retire_cnt = w_retire_cnt + CW'(w_stat[k].expired);
        end
    end

    // victim search token enters the first cell
    assign w_tok[0] = '{vld: w_scan_go, done: 1'b0, idx: '0, expiry: 32'd0};

    // cell chain
    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
            pmc_cell #(.IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1]),
                .o_stat  (w_stat[g])
            );
        end
    endgenerate

    // sequencer: evaluate, optional victim search, deliver
    always_comb begin
        n_state      = r_state;
        n_cur_time   = r_cur_time;
        n_cnt_upd    = r_cnt_upd;
        n_cnt_hit    = r_cnt_hit;
        n_cnt_exp    = r_cnt_exp;
        n_res_status = r_res_status;
        n_res_mtu    = r_res_mtu;
        w_cmd.op        = OP_NONE;
        w_cmd.is_v6     = r_is_v6;
        w_cmd.addr_high = r_hi;
        w_cmd.addr_low  = r_lo;
        w_cmd.mtu       = (r_state == S_SCAN) ? r_clamp : w_clamp;
        w_cmd.exp_new   = r_cur_time + r_lifetime;
        w_cmd.cmp_time  = (r_cmd == CMD_TICK) ? r_tick : r_cur_time;
        w_cmd.pick      = w_tok[NUM_SLOTS].idx;
        w_scan_go       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state      = S_DONE;
                n_res_status = ST_DEFAULT;
                n_res_mtu    = 16'd0;
                unique case (r_cmd)
                    CMD_TICK: begin
                        w_cmd.op   = OP_TICK;
                        n_cur_time = r_tick;
                        n_cnt_exp  = r_cnt_exp + 32'(w_retire_cnt);
                    end
                    CMD_UPDATE: begin
                        if (w_bad) begin
                            n_res_status = ST_REJECTED;
                        end else begin
                            n_res_mtu = w_clamp;
                            if (w_any_match && (w_clamp >= w_m_mtu)) begin
                                w_cmd.op     = OP_REFRESH;
                                n_res_status = ST_REFRESHED;
                            end else if (w_any_match) begin
                                w_cmd.op     = OP_LOWER;
                                n_res_status = ST_STORED;
                                n_cnt_upd    = r_cnt_upd + 32'd1;
                            end else begin
                                w_scan_go    = 1'b1;
                                n_state      = S_SCAN;
                            end
                        end
                    end
                    CMD_LOOKUP: begin
                        n_res_mtu = r_ceil;
                        if (!w_addr_zero && (r_ceil != 16'd0) && w_any_match) begin
                            if (w_m_expired) begin
                                w_cmd.op  = OP_RETIRE;
                                n_cnt_exp = r_cnt_exp + 32'd1;
                            end else begin
                                n_cnt_hit    = r_cnt_hit + 32'd1;
                                n_res_status = ST_HIT;
                                n_res_mtu    = (w_m_mtu < r_ceil) ? w_m_mtu : r_ceil;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                if (w_tok[NUM_SLOTS].vld) begin
                    w_cmd.op     = OP_INSERT;
                    n_res_status = ST_STORED;
                    n_cnt_upd    = r_cnt_upd + 32'd1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur_time <= 32'd0;
            r_cnt_upd  <= 32'd0;
            r_cnt_hit  <= 32'd0;
            r_cnt_exp  <= 32'd0;
        end else begin
            r_state    <= n_state;
            r_cur_time <= n_cur_time;
            r_cnt_upd  <= n_cnt_upd;
            r_cnt_hit  <= n_cnt_hit;
            r_cnt_exp  <= n_cnt_exp;
        end
        r_res_status <= n_res_status;
        r_res_mtu    <= n_res_mtu;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if ((r_state == S_DONE) && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= {r_cnt_exp, r_cnt_hit, r_cnt_upd, r_res_mtu};
            r_out_user <= r_res_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

[rtl/pmc_checker.sv]
// ---------------------------------------------------------------------------
// pmc_checker
// port-level checks on the path mtu cache, bound to the top level
// ---------------------------------------------------------------------------
`include "path_mtu_cache_unit_assert.svh"

module pmc_checker
    import pmc_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);

    // a held result does not change
    `PMC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> $stable({m_axis_tdata, m_axis_tuser}), "result changed")

    // reset leaves no result pending
    `PMC_ASSERT_RST(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // a rejected update reports no mtu
    `PMC_ASSERT(a_reject_zero, m_axis_tvalid && (m_axis_tuser == ST_REJECTED) |-> m_axis_tdata[15:0] == 16'd0, "reject with mtu")

    // one item in work: no accept in the cycle after an accept
    `PMC_ASSERT(a_one_item, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second item taken during work")

endmodule

bind path_mtu_cache_unit pmc_checker u_pmc_checker (.*);
